// ----- src/ptre_pkg.sv -----
// Shared types and constants for the pixel threshold run extractor.
`default_nettype none

package ptre_pkg;

   // Coordinate arithmetic keeps only the low COORD_BITS bits of each coordinate.
   localparam int COORD_BITS = 12;
   localparam int FIELD_BITS = 12;
   localparam logic [FIELD_BITS-1:0] COORD_MASK =
      FIELD_BITS'((64'd1 << COORD_BITS) - 64'd1);

   // Threshold reset value and register indexes.
   localparam logic [7:0] LIMIT_RESET = 8'd127;

   typedef enum logic [1:0] {
      CSR_RED_LIMIT   = 2'd0,
      CSR_GREEN_LIMIT = 2'd1,
      CSR_BLUE_LIMIT  = 2'd2
   } csr_index_type;

   // Result kinds.
   localparam logic KIND_SEGMENT = 1'b0;
   localparam logic KIND_BOX     = 1'b1;

   typedef struct packed {
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic [7:0]            alpha;
      logic [FIELD_BITS-1:0] column;
      logic [FIELD_BITS-1:0] row;
      logic                  row_end;
      logic                  frame_start;
      logic                  frame_end;
   } req_type;

   typedef struct packed {
      logic                  kind;
      logic [FIELD_BITS-1:0] start_x;
      logic [FIELD_BITS-1:0] start_y;
      logic [FIELD_BITS-1:0] end_x;
      logic [FIELD_BITS-1:0] end_y;
      logic                  empty_res;
      logic                  last;
   } rsp_type;

   // Results that one pixel produces: a count of zero to two, in order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } res_group_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } limits_type;

endpackage

`default_nettype wire

// ----- src/ptre_engine.sv -----
// Run and bounding box state, pixel selection and result forming.
`default_nettype none

module ptre_engine
   import ptre_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire req_type       item,
   input  wire limits_type    limits,
   input  wire logic          advance,
   output      res_group_type results
);

   logic                  run_open_ff, run_open_in;
   logic [FIELD_BITS-1:0] run_first_x_ff, run_first_x_in;
   logic [FIELD_BITS-1:0] run_first_y_ff, run_first_y_in;
   logic [FIELD_BITS-1:0] run_last_x_ff, run_last_x_in;
   logic [FIELD_BITS-1:0] run_last_y_ff, run_last_y_in;
   logic [FIELD_BITS-1:0] box_min_x_ff, box_min_x_in;
   logic [FIELD_BITS-1:0] box_min_y_ff, box_min_y_in;
   logic [FIELD_BITS-1:0] box_max_x_ff, box_max_x_in;
   logic [FIELD_BITS-1:0] box_max_y_ff, box_max_y_in;
   logic                  any_selected_ff, any_selected_in;

   logic                  eff_open;
   logic [FIELD_BITS-1:0] eff_first_x, eff_first_y, eff_last_x, eff_last_y;
   logic [FIELD_BITS-1:0] eff_min_x, eff_min_y, eff_max_x, eff_max_y;
   logic                  eff_any;
   logic [FIELD_BITS-1:0] px, py;
   logic                  selected, closing_edge, seg_valid;
   rsp_type               seg_res, box_res;

   // A frame start clears the state before the pixel is looked at.
   always_comb begin
      eff_open    = item.frame_start ? 1'b0 : run_open_ff;
      eff_first_x = item.frame_start ? '0 : run_first_x_ff;
      eff_first_y = item.frame_start ? '0 : run_first_y_ff;
      eff_last_x  = item.frame_start ? '0 : run_last_x_ff;
      eff_last_y  = item.frame_start ? '0 : run_last_y_ff;
      eff_min_x   = item.frame_start ? COORD_MASK : box_min_x_ff;
      eff_min_y   = item.frame_start ? COORD_MASK : box_min_y_ff;
      eff_max_x   = item.frame_start ? '0 : box_max_x_ff;
      eff_max_y   = item.frame_start ? '0 : box_max_y_ff;
      eff_any     = item.frame_start ? 1'b0 : any_selected_ff;
   end

   // Threshold test and masked coordinates.
   always_comb begin
      px = item.column & COORD_MASK;
      py = item.row & COORD_MASK;
      selected = (item.alpha != 8'd0) && (item.red <= limits.red) &&
                 (item.green <= limits.green) && (item.blue <= limits.blue);
      closing_edge = item.row_end || item.frame_end;
   end

   // Next run and box state.
   always_comb begin
      run_first_x_in  = eff_first_x;
      run_first_y_in  = eff_first_y;
      run_last_x_in   = eff_last_x;
      run_last_y_in   = eff_last_y;
      box_min_x_in    = eff_min_x;
      box_min_y_in    = eff_min_y;
      box_max_x_in    = eff_max_x;
      box_max_y_in    = eff_max_y;
      any_selected_in = eff_any || selected;
      run_open_in     = selected && !closing_edge;
      if (selected) begin
         if (!eff_open) begin
            run_first_x_in = px;
            run_first_y_in = py;
         end
         run_last_x_in = px;
         run_last_y_in = py;
         if (px < eff_min_x) box_min_x_in = px;
         if (py < eff_min_y) box_min_y_in = py;
         if (px > eff_max_x) box_max_x_in = px;
         if (py > eff_max_y) box_max_y_in = py;
      end
   end

   // A run closes on an unselected pixel, or at a row or frame end.
   always_comb begin
      seg_valid = selected ? closing_edge : eff_open;
      seg_res.kind      = KIND_SEGMENT;
      seg_res.start_x   = run_first_x_in;
      seg_res.start_y   = run_first_y_in;
      seg_res.end_x     = run_last_x_in;
      seg_res.end_y     = run_last_y_in;
      seg_res.empty_res = 1'b0;
      seg_res.last      = !item.frame_end;

      box_res.kind      = KIND_BOX;
      box_res.start_x   = any_selected_in ? box_min_x_in : '0;
      box_res.start_y   = any_selected_in ? box_min_y_in : '0;
      box_res.end_x     = any_selected_in ? box_max_x_in : '0;
      box_res.end_y     = any_selected_in ? box_max_y_in : '0;
      box_res.empty_res = !any_selected_in;
      box_res.last      = 1'b1;

      results.count  = {1'b0, seg_valid} + {1'b0, item.frame_end};
      results.first  = seg_valid ? seg_res : box_res;
      results.second = box_res;
   end

   // State registers, updated when the pixel leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff     <= 1'b0;
         run_first_x_ff  <= '0;
         run_first_y_ff  <= '0;
         run_last_x_ff   <= '0;
         run_last_y_ff   <= '0;
         box_min_x_ff    <= COORD_MASK;
         box_min_y_ff    <= COORD_MASK;
         box_max_x_ff    <= '0;
         box_max_y_ff    <= '0;
         any_selected_ff <= 1'b0;
      end else if (advance) begin
         run_open_ff     <= run_open_in;
         run_first_x_ff  <= run_first_x_in;
         run_first_y_ff  <= run_first_y_in;
         run_last_x_ff   <= run_last_x_in;
         run_last_y_ff   <= run_last_y_in;
         box_min_x_ff    <= box_min_x_in;
         box_min_y_ff    <= box_min_y_in;
         box_max_x_ff    <= box_max_x_in;
         box_max_y_ff    <= box_max_y_in;
         any_selected_ff <= any_selected_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/pixel_threshold_run_extractor.sv -----
// Top level of the pixel threshold run extractor.
//
// Pixels arrive on the req_ channel (valid/ready) in scan order, each with its
// coordinates and row end, frame start and frame end marks. A pixel is selected
// when alpha is nonzero and red, green and blue are at or below their limits.
// Each closed run of selected pixels gives a segment result on the rsp_ channel;
// a frame end pixel also gives a bounding box summary after any segment, and
// the last result of a pixel carries last.
// The csr_ channel writes the three limits (index 0 red, 1 green, 2 blue); it is
// always ready, and writes to other indexes are dropped.
// A result passes through the input register, then a two-entry result buffer,
// before it is offered on the rsp_ channel.
// Throughput: one request per cycle while the result
// buffer can take the results of the pixel held in the input register; a pixel
// that gives two results needs both entries free.
// Reset clears the run and box state, empties the buffer and sets every limit
// to 127. When the receiver stalls, results collect in the buffer and the input
// register holds its pixel, which then drops req_ready.
`default_nettype none

module pixel_threshold_run_extractor
   import ptre_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire req_type    req_data,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      rsp_type    rsp_data,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);

   limits_type    limits_ff;
   logic          a_valid_ff;
   req_type       a_item_ff;
   logic [1:0]    cnt_ff, cnt_in;
   rsp_type       slot0_ff, slot0_in;
   rsp_type       slot1_ff, slot1_in;
   res_group_type results;
   logic          pop, advance;
   logic [1:0]    kept;
   logic [2:0]    room_sum;

   // Limit registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.red   <= LIMIT_RESET;
         limits_ff.green <= LIMIT_RESET;
         limits_ff.blue  <= LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RED_LIMIT:   limits_ff.red   <= csr_data;
            CSR_GREEN_LIMIT: limits_ff.green <= csr_data;
            CSR_BLUE_LIMIT:  limits_ff.blue  <= csr_data;
            default: ;
         endcase
      end
   end

   // Flow control: the held pixel moves on when the buffer can take its results.
   always_comb begin
      pop       = rsp_valid && rsp_ready;
      kept      = cnt_ff - {1'b0, pop};
      room_sum  = {1'b0, kept} + {1'b0, results.count};
      advance   = a_valid_ff && (room_sum <= 3'd2);
      req_ready = !a_valid_ff || advance;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         a_item_ff <= req_data;
      end
   end

   ptre_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .item    (a_item_ff),
      .limits  (limits_ff),
      .advance (advance),
      .results (results)
   );

   // Result buffer: slot 0 drives the response, new results append behind.
   always_comb begin
      cnt_in   = advance ? room_sum[1:0] : kept;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (kept != 2'd0) begin
         slot0_in = pop ? slot1_ff : slot0_ff;
      end else begin
         slot0_in = results.first;
      end
      unique case (kept)
         2'd0:    slot1_in = results.second;
         2'd1:    slot1_in = results.first;
         default: slot1_in = slot1_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   // The buffer never holds more than two results.
   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer overfilled");

   // A pixel with two results only moves on into an empty buffer.
   a_pair_room : assert property (@(posedge clock) disable iff (reset)
      (advance && results.count == 2'd2) |-> (kept == 2'd0))
      else $error("two results pushed without room");

   // A frame end always yields a box summary, which is the final result.
   a_frame_end_box : assert property (@(posedge clock) disable iff (reset)
      (advance && a_item_ff.frame_end) |=>
         (rsp_valid && (slot0_ff.kind == KIND_BOX || slot1_ff.kind == KIND_BOX)))
      else $error("frame end without box summary");

   // When two results come together, a segment precedes the box.
   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && results.count == 2'd2) |->
         (results.first.kind == KIND_SEGMENT && results.second.kind == KIND_BOX &&
          !results.first.last))
      else $error("bad order of paired results");

endmodule

`default_nettype wire
